@@ src/sspa_pkg.sv @@
// Shared types and constants of the slot pool allocator.
package sspa_pkg;

	localparam int MAX_SLOTS  = 256;
	localparam int SLOT_BYTES = 32;
	localparam int SLOT_SHIFT = $clog2(SLOT_BYTES);
	localparam int WORD_BITS  = 32;
	localparam int NUM_WORDS  = MAX_SLOTS / WORD_BITS;
	localparam int BIT_IDX_W  = $clog2(WORD_BITS);
	localparam int WORD_IDX_W = $clog2(NUM_WORDS);
	localparam int IDX_W      = WORD_IDX_W + BIT_IDX_W;
	localparam int CNT_W      = IDX_W + 1;
	localparam int ADDR_W     = 32;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT   = 1'd1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_ALLOCATED    = 3'd0,
		STAT_EMPTY        = 3'd1,
		STAT_FREED        = 3'd2,
		STAT_NOT_IN_POOL  = 3'd3,
		STAT_ALREADY_FREE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_FREE,
		ST_FINISH
	} state_t;

	// TAKE claims the slot found; REHINT only moves the hint there
	typedef enum logic {
		SCAN_TAKE,
		SCAN_REHINT
	} scan_mode_t;

	typedef struct packed {
		logic                  found;
		logic [BIT_IDX_W-1:0]  pos;
	} scan_res_t;

	typedef struct packed {
		logic                  we;
		logic [WORD_IDX_W-1:0] addr;
		logic [WORD_BITS-1:0]  data;
	} bm_wr_t;

endpackage

@@ src/sspa_if.sv @@
// Valid/ready channels for commands and responses of the slot pool allocator.
interface sspa_cmd_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] address;

	modport source (output valid, output command, output address, input ready);
	modport sink (input valid, input command, input address, output ready);
endinterface

interface sspa_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] slot_address;
	logic [7:0]  slot_index;
	logic [8:0]  free_slots;
	logic [8:0]  fewest_free;

	modport source (output valid, output status, output slot_address, output slot_index,
		output free_slots, output fewest_free, input ready);
	modport sink (input valid, input status, input slot_address, input slot_index,
		input free_slots, input fewest_free, output ready);
endinterface

@@ src/sspa_bitmap.sv @@
// Occupancy bitmap: one bit per slot, held as words with one read and one write port.
module sspa_bitmap (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clr,
	input  sspa_pkg::bm_wr_t               wr,
	input  logic [sspa_pkg::WORD_IDX_W-1:0] rd_addr,
	output logic [sspa_pkg::WORD_BITS-1:0]  rd_word
);
	import sspa_pkg::*;

	logic [WORD_BITS-1:0] words_q [NUM_WORDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				words_q[i] <= '0;
			end
		end else if (clr) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				words_q[i] <= '0;
			end
		end else if (wr.we) begin
			words_q[wr.addr] <= wr.data;
		end
	end

	assign rd_word = words_q[rd_addr];

endmodule

@@ src/sspa_scan.sv @@
// Find-first-free unit: lowest clear bit of one bitmap word inside [start, limit).
module sspa_scan (
	input  logic [sspa_pkg::WORD_BITS-1:0]  word,
	input  logic [sspa_pkg::WORD_IDX_W-1:0] word_idx,
	input  logic [sspa_pkg::CNT_W-1:0]      start,
	input  logic [sspa_pkg::CNT_W-1:0]      limit,
	output sspa_pkg::scan_res_t             res
);
	import sspa_pkg::*;

	logic [WORD_BITS-1:0]  masked;
	logic [WORD_IDX_W-1:0] start_w;
	logic [BIT_IDX_W-1:0]  start_b;
	logic [WORD_IDX_W-1:0] lim_w;
	logic [BIT_IDX_W-1:0]  lim_b;
	logic                  lim_full;

	assign start_w  = start[IDX_W-1:BIT_IDX_W];
	assign start_b  = start[BIT_IDX_W-1:0];
	assign lim_w    = limit[IDX_W-1:BIT_IDX_W];
	assign lim_b    = limit[BIT_IDX_W-1:0];
	assign lim_full = limit[IDX_W];

	// treat slots below start or at/above limit as taken
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			masked[b] = word[b]
				| ((word_idx == start_w) && (BIT_IDX_W'(b) < start_b))
				| (!lim_full && ((word_idx > lim_w)
					|| ((word_idx == lim_w) && (BIT_IDX_W'(b) >= lim_b))));
		end
	end

	always_comb begin
		res.found = ~&masked;
		res.pos   = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!masked[b]) begin
				res.pos = BIT_IDX_W'(b);
			end
		end
	end

endmodule

@@ src/small_slot_pool_allocator_top.sv @@
// Pool of up to 256 fixed 32-byte slots: allocate and free one slot per command
// word, with a first-free hint, a free count and a low-water mark of that count.
// The block takes one command at a time. A free command passes the free check;
// an allocate with an empty pool goes straight to the finish; any other allocate
// checks the hint, then the shared find-first-free unit scans 1 to 8 of the
// 32-slot bitmap words. Ready returns the cycle after the response word is loaded.
// A response waiting at the output holds the next command in its last step only.
// Writing slot_count empties the pool at once.
module small_slot_pool_allocator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	sspa_cmd_if.sink                      cmd,
	sspa_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [sspa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import sspa_pkg::*;

	state_t                state_q, state_d;
	scan_mode_t            mode_q, mode_d;
	status_t               status_q, status_d;
	logic [ADDR_W-1:0]     base_q, base_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [CNT_W-1:0]      hint_q, hint_d;
	logic [CNT_W-1:0]      free_q, free_d;
	logic [CNT_W-1:0]      low_q, low_d;
	logic [CNT_W-1:0]      start_q, start_d;
	logic [WORD_IDX_W-1:0] word_q, word_d;
	logic [IDX_W-1:0]      idx_q, idx_d;
	logic [ADDR_W-1:0]     addr_q, addr_d;

	logic                  rsp_valid_q, rsp_valid_d;
	status_t               rsp_status_q, rsp_status_d;
	logic [ADDR_W-1:0]     rsp_addr_q, rsp_addr_d;
	logic [IDX_W-1:0]      rsp_idx_q, rsp_idx_d;
	logic [CNT_W-1:0]      rsp_free_q, rsp_free_d;
	logic [CNT_W-1:0]      rsp_low_q, rsp_low_d;

	logic                  bm_clr;
	bm_wr_t                bm_wr;
	logic [WORD_IDX_W-1:0] rd_addr;
	logic [WORD_BITS-1:0]  rd_word;
	scan_res_t             scan_res;

	logic [CNT_W-1:0]      free_dec;
	logic [CNT_W-1:0]      low_dec;
	logic [CNT_W-1:0]      count_sat;
	logic [ADDR_W:0]       diff;
	logic                  in_pool;
	logic [IDX_W-1:0]      free_idx;
	logic [IDX_W-1:0]      found_idx;
	logic                  exhausted;

	sspa_bitmap u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (bm_clr),
		.wr      (bm_wr),
		.rd_addr (rd_addr),
		.rd_word (rd_word)
	);

	sspa_scan u_scan (
		.word     (rd_word),
		.word_idx (word_q),
		.start    (start_q),
		.limit    (count_q),
		.res      (scan_res)
	);

	assign free_dec  = free_q - CNT_W'(1);
	assign low_dec   = (free_dec < low_q) ? free_dec : low_q;
	assign count_sat = (cfg_data[CNT_W-1:0] > CNT_W'(MAX_SLOTS))
		? CNT_W'(MAX_SLOTS) : cfg_data[CNT_W-1:0];
	assign diff      = {1'b0, addr_q} - {1'b0, base_q};
	assign in_pool   = !diff[ADDR_W]
		&& (diff[ADDR_W-1:SLOT_SHIFT] < (ADDR_W - SLOT_SHIFT)'(count_q));
	assign free_idx  = diff[IDX_W+SLOT_SHIFT-1:SLOT_SHIFT];
	assign found_idx = {word_q, scan_res.pos};
	assign exhausted = start_q >= count_q;

	assign cmd.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			count_q     <= '0;
			hint_q      <= '0;
			free_q      <= '0;
			low_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			base_q      <= base_d;
			count_q     <= count_d;
			hint_q      <= hint_d;
			free_q      <= free_d;
			low_q       <= low_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q       <= mode_d;
		status_q     <= status_d;
		start_q      <= start_d;
		word_q       <= word_d;
		idx_q        <= idx_d;
		addr_q       <= addr_d;
		rsp_status_q <= rsp_status_d;
		rsp_addr_q   <= rsp_addr_d;
		rsp_idx_q    <= rsp_idx_d;
		rsp_free_q   <= rsp_free_d;
		rsp_low_q    <= rsp_low_d;
	end

	always_comb begin
		state_d      = state_q;
		mode_d       = mode_q;
		status_d     = status_q;
		base_d       = base_q;
		count_d      = count_q;
		hint_d       = hint_q;
		free_d       = free_q;
		low_d        = low_q;
		start_d      = start_q;
		word_d       = word_q;
		idx_d        = idx_q;
		addr_d       = addr_q;
		rsp_valid_d  = rsp_valid_q && !rsp.ready;
		rsp_status_d = rsp_status_q;
		rsp_addr_d   = rsp_addr_q;
		rsp_idx_d    = rsp_idx_q;
		rsp_free_d   = rsp_free_q;
		rsp_low_d    = rsp_low_q;
		bm_clr       = 1'b0;
		bm_wr.we     = 1'b0;
		bm_wr.addr   = word_q;
		bm_wr.data   = rd_word;
		rd_addr      = word_q;

		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					addr_d = cmd.address;
					if (cmd.command == CMD_FREE) begin
						state_d = ST_FREE;
					end else if (free_q == '0) begin
						status_d = STAT_EMPTY;
						idx_d    = '0;
						state_d  = ST_FINISH;
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				rd_addr = hint_q[IDX_W-1:BIT_IDX_W];
				status_d = STAT_ALLOCATED;
				state_d  = ST_SCAN;
				if ((hint_q < count_q) && !rd_word[hint_q[BIT_IDX_W-1:0]]) begin
					// take the hinted slot, then look for the next free one above it
					bm_wr.we   = 1'b1;
					bm_wr.addr = hint_q[IDX_W-1:BIT_IDX_W];
					bm_wr.data = rd_word | (WORD_BITS'(1) << hint_q[BIT_IDX_W-1:0]);
					free_d     = free_dec;
					low_d      = low_dec;
					idx_d      = hint_q[IDX_W-1:0];
					start_d    = hint_q + CNT_W'(1);
					word_d     = start_d[IDX_W-1:BIT_IDX_W];
					mode_d     = SCAN_REHINT;
				end else begin
					start_d = '0;
					word_d  = '0;
					mode_d  = SCAN_TAKE;
				end
			end
			ST_SCAN: begin
				rd_addr = word_q;
				if (!exhausted && scan_res.found) begin
					state_d = ST_FINISH;
					if (mode_q == SCAN_REHINT) begin
						hint_d = {1'b0, found_idx};
					end else begin
						bm_wr.we   = 1'b1;
						bm_wr.addr = word_q;
						bm_wr.data = rd_word | (WORD_BITS'(1) << scan_res.pos);
						free_d     = free_dec;
						low_d      = low_dec;
						idx_d      = found_idx;
						status_d   = STAT_ALLOCATED;
					end
				end else if (exhausted || (word_q == WORD_IDX_W'(NUM_WORDS - 1))) begin
					state_d = ST_FINISH;
					if (mode_q == SCAN_REHINT) begin
						hint_d = count_q;
					end else begin
						status_d = STAT_EMPTY;
						idx_d    = '0;
					end
				end else begin
					word_d = word_q + WORD_IDX_W'(1);
				end
			end
			ST_FREE: begin
				rd_addr = free_idx[IDX_W-1:BIT_IDX_W];
				state_d = ST_FINISH;
				if (!in_pool) begin
					status_d = STAT_NOT_IN_POOL;
					idx_d    = '0;
				end else if (!rd_word[free_idx[BIT_IDX_W-1:0]]) begin
					status_d = STAT_ALREADY_FREE;
					idx_d    = free_idx;
				end else begin
					bm_wr.we   = 1'b1;
					bm_wr.addr = free_idx[IDX_W-1:BIT_IDX_W];
					bm_wr.data = rd_word & ~(WORD_BITS'(1) << free_idx[BIT_IDX_W-1:0]);
					free_d     = free_q + CNT_W'(1);
					if (hint_q > {1'b0, free_idx}) begin
						hint_d = {1'b0, free_idx};
					end
					status_d = STAT_FREED;
					idx_d    = free_idx;
				end
			end
			ST_FINISH: begin
				// hold until the output register is free
				if (!rsp_valid_q || rsp.ready) begin
					rsp_valid_d  = 1'b1;
					rsp_status_d = status_q;
					rsp_idx_d    = idx_q;
					rsp_free_d   = free_q;
					rsp_low_d    = low_q;
					if (status_q inside {STAT_ALLOCATED, STAT_FREED, STAT_ALREADY_FREE}) begin
						rsp_addr_d = base_q + ADDR_W'({idx_q, {SLOT_SHIFT{1'b0}}});
					end else begin
						rsp_addr_d = '0;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (cfg_we) begin
			case (cfg_index)
				CFG_BASE_ADDRESS: begin
					base_d = cfg_data;
				end
				CFG_SLOT_COUNT: begin
					count_d = count_sat;
					hint_d  = '0;
					free_d  = count_sat;
					low_d   = count_sat;
					bm_clr  = 1'b1;
				end
				default: begin
					base_d = base_q;
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.slot_address = rsp_addr_q;
	assign rsp.slot_index   = rsp_idx_q;
	assign rsp.free_slots   = rsp_free_q;
	assign rsp.fewest_free  = rsp_low_q;

endmodule

@@ bench/tb_small_slot_pool_allocator_top.sv @@
// Self-checking bench for the slot pool allocator: directed and random command words.
module tb_small_slot_pool_allocator_top;
	import sspa_pkg::*;

	localparam int QUIET_LIMIT     = 5000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 20;
	localparam int RANDOM_ITEMS    = 800;

	typedef struct packed {
		status_t     status;
		logic [31:0] slot_address;
		logic [7:0]  slot_index;
		logic [8:0]  free_slots;
		logic [8:0]  fewest_free;
	} pool_rsp_t;

	// Mirrors the pool: bitmap, hint, free count and low-water mark.
	class slot_pool_tracker;
		bit          occupied [MAX_SLOTS];
		logic [8:0]  hint;
		logic [8:0]  free_total;
		logic [8:0]  low_water;
		logic [8:0]  slot_count;
		logic [31:0] base;
		pool_rsp_t   pending_rsp [$];
		int          mismatches;

		function new();
			base       = '0;
			mismatches = 0;
			configure(CFG_SLOT_COUNT, '0);
		endfunction

		function void configure(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			if (idx == CFG_BASE_ADDRESS) begin
				base = data;
			end else begin
				slot_count = (data[8:0] > MAX_SLOTS) ? 9'(MAX_SLOTS) : data[8:0];
				foreach (occupied[i]) occupied[i] = 1'b0;
				hint       = '0;
				free_total = slot_count;
				low_water  = slot_count;
			end
		endfunction

		function logic [31:0] slot_addr(int idx);
			return base + 32'(idx * SLOT_BYTES);
		endfunction

		function void take(int idx);
			occupied[idx] = 1'b1;
			free_total--;
			if (free_total < low_water)
				low_water = free_total;
		endfunction

		function pool_rsp_t reply(status_t st, logic [31:0] a, logic [7:0] i);
			pool_rsp_t r;
			r.status       = st;
			r.slot_address = a;
			r.slot_index   = i;
			r.free_slots   = free_total;
			r.fewest_free  = low_water;
			return r;
		endfunction

		function void note_command(logic cmd, logic [31:0] addr);
			pool_rsp_t   r;
			int          idx;
			logic [31:0] offset;
			idx = -1;
			if (cmd == CMD_ALLOC) begin
				if (free_total == 0) begin
					r = reply(STAT_EMPTY, '0, '0);
				end else if (hint < slot_count && !occupied[hint]) begin
					idx = int'(hint);
					take(idx);
					// advance the hint to the next free slot above, else park at the count
					hint = slot_count;
					for (int i = idx + 1; i < slot_count; i++) begin
						if (!occupied[i]) begin
							hint = 9'(i);
							break;
						end
					end
					r = reply(STAT_ALLOCATED, slot_addr(idx), 8'(idx));
				end else begin
					for (int i = 0; i < slot_count; i++) begin
						if (!occupied[i]) begin
							idx = i;
							break;
						end
					end
					if (idx < 0) begin
						r = reply(STAT_EMPTY, '0, '0);
					end else begin
						take(idx);
						r = reply(STAT_ALLOCATED, slot_addr(idx), 8'(idx));
					end
				end
			end else begin
				offset = addr - base;
				if (addr < base || offset >= 32'(slot_count) * 32'(SLOT_BYTES)) begin
					r = reply(STAT_NOT_IN_POOL, '0, '0);
				end else begin
					idx = int'(offset / 32'(SLOT_BYTES));
					if (!occupied[idx]) begin
						r = reply(STAT_ALREADY_FREE, slot_addr(idx), 8'(idx));
					end else begin
						occupied[idx] = 1'b0;
						if (int'(hint) > idx)
							hint = 9'(idx);
						free_total++;
						r = reply(STAT_FREED, slot_addr(idx), 8'(idx));
					end
				end
			end
			pending_rsp.push_back(r);
		endfunction

		function void check_response(pool_rsp_t got);
			pool_rsp_t want;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response word: status %0d addr %h idx %0d",
						got.status, got.slot_address, got.slot_index);
				return;
			end
			want = pending_rsp.pop_front();
			if (got.status !== want.status || got.slot_address !== want.slot_address ||
				got.slot_index !== want.slot_index || got.free_slots !== want.free_slots ||
				got.fewest_free !== want.fewest_free) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: expected status %0d addr %h idx %0d free %0d fewest %0d",
						want.status, want.slot_address, want.slot_index, want.free_slots,
						want.fewest_free);
					$display("          got status %0d addr %h idx %0d free %0d fewest %0d",
						got.status, got.slot_address, got.slot_index, got.free_slots,
						got.fewest_free);
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	bit                   idle_on = 1'b1;
	int                   pressure_requests = 0;
	int                   quiet_cycles = 0;

	slot_pool_tracker tracker = new();

	sspa_cmd_if cmd_ch ();
	sspa_rsp_if rsp_ch ();

	small_slot_pool_allocator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	// Response side: random stalls, plus a long hold-off when asked for.
	initial begin
		int served;
		served       = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (pressure_requests > served) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
				served++;
			end else begin
				rsp_ch.ready <= (!idle_on || $urandom_range(99) >= 24);
			end
		end
	end

	// Observe both channels and watch for a hang.
	always @(posedge clk) begin
		pool_rsp_t got;
		if (rsp_ch.valid && rsp_ch.ready) begin
			got.status       = status_t'(rsp_ch.status);
			got.slot_address = rsp_ch.slot_address;
			got.slot_index   = rsp_ch.slot_index;
			got.free_slots   = rsp_ch.free_slots;
			got.fewest_free  = rsp_ch.fewest_free;
			tracker.check_response(got);
		end
		if (cmd_ch.valid && cmd_ch.ready)
			tracker.note_command(cmd_ch.command, cmd_ch.address);
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic send_command(logic c, logic [31:0] a);
		while (idle_on && $urandom_range(99) < 24) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.command <= c;
		cmd_ch.address <= a;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	// Drop valid, drain all responses, wait for ready, then write one register.
	task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (tracker.pending_rsp.size() != 0 || !cmd_ch.ready);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		tracker.configure(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int          random_items;
		int          ph;
		int          cnt;
		int          n;
		int          alloc_pct;
		int          idx;
		int          r;
		logic [31:0] a;
		arst_n         = 1'b0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.command = CMD_ALLOC;
		cmd_ch.address = '0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_BASE_ADDRESS;
		cfg_data       = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero slots after reset: nothing to allocate, nothing inside the pool.
		send_command(CMD_ALLOC, 32'hFFFF_FFFF);
		send_command(CMD_FREE, 32'h0000_0000);

		// Top base with an oversized count: addresses wrap, count saturates.
		set_register(CFG_BASE_ADDRESS, 32'hFFFF_FFE0);
		set_register(CFG_SLOT_COUNT, 32'd511);
		send_command(CMD_ALLOC, 32'h0);
		send_command(CMD_ALLOC, 32'h0);
		send_command(CMD_FREE, 32'hFFFF_FFE5);
		send_command(CMD_FREE, 32'hFFFF_FFFF);
		send_command(CMD_FREE, 32'h0000_0010);
		send_command(CMD_ALLOC, 32'h0);
		send_command(CMD_FREE, 32'h0000_001F);

		// One slot: fill, empty pool, unaligned free, both pool edges, double free.
		set_register(CFG_BASE_ADDRESS, 32'h0000_1000);
		set_register(CFG_SLOT_COUNT, 32'd1);
		send_command(CMD_ALLOC, 32'h0);
		send_command(CMD_ALLOC, 32'h0);
		send_command(CMD_FREE, 32'h0000_101F);
		send_command(CMD_FREE, 32'h0000_1020);
		send_command(CMD_FREE, 32'h0000_0FFF);
		send_command(CMD_FREE, 32'h0000_1000);

		// Full pool at base zero: last slot and one past it.
		set_register(CFG_BASE_ADDRESS, 32'h0);
		set_register(CFG_SLOT_COUNT, 32'd256);
		send_command(CMD_FREE, 32'h0000_1FFF);
		send_command(CMD_FREE, 32'h0000_2000);
		send_command(CMD_ALLOC, 32'hA5A5_5A5A);

		random_items = 0;
		ph = 0;
		while (random_items < RANDOM_ITEMS) begin
			case (ph % 6)
				0:       cnt = 256;
				1:       cnt = 1;
				2:       cnt = $urandom_range(2, 8);
				3:       cnt = $urandom_range(9, 255);
				4:       cnt = $urandom_range(257, 511);
				default: cnt = 0;
			endcase
			set_register(CFG_BASE_ADDRESS, {27'($urandom_range(32'h07FF_FFFF, 0)), 5'b0});
			set_register(CFG_SLOT_COUNT, 32'(cnt));
			cnt       = int'(tracker.slot_count);
			n         = (cnt >= 64) ? 250 : 60;
			if (n > RANDOM_ITEMS - random_items)
				n = RANDOM_ITEMS - random_items;
			alloc_pct = (cnt >= 64) ? 80 : $urandom_range(35, 70);
			idle_on   = (ph != 2);
			// stall the response side while commands keep coming
			if (ph == 1)
				pressure_requests++;
			repeat (n) begin
				if ($urandom_range(99) < alloc_pct) begin
					send_command(CMD_ALLOC, $urandom());
				end else begin
					r = $urandom_range(99);
					if (r < 70 && cnt > 0) begin
						idx = $urandom_range(cnt - 1);
						// mostly aim at a taken slot
						if ($urandom_range(3) != 0) begin
							for (int k = 0; k < cnt; k++) begin
								if (tracker.occupied[(idx + k) % cnt]) begin
									idx = (idx + k) % cnt;
									break;
								end
							end
						end
						a = tracker.base + 32'(idx * SLOT_BYTES) + 32'($urandom_range(31));
					end else if (r < 85) begin
						case ($urandom_range(3))
							0:       a = tracker.base - 32'd1;
							1:       a = tracker.base + 32'(cnt * SLOT_BYTES);
							2:       a = tracker.base + 32'(cnt * SLOT_BYTES) - 32'd1;
							default: a = tracker.base;
						endcase
					end else begin
						a = $urandom();
					end
					send_command(CMD_FREE, a);
				end
				random_items++;
			end
			ph++;
		end
		idle_on = 1'b1;

		cmd_ch.valid <= 1'b0;
		while (tracker.pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_rsp.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
